FILE: src/tbt_pkg.sv
package tbt_pkg;

  // Default number of team slots in the table.
  localparam int TEAM_SLOTS_DEF = 16;

  // Payload widths fixed by the interface.
  localparam int MODE_W   = 2;
  localparam int SIZE_W   = 9;
  localparam int ID_W     = 16;
  localparam int SLOT_W   = 8;
  localparam int SLOTO_W  = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_NEW    = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_DEL    = 2'd2,
    MODE_ARRIVE = 2'd3
  } mode_t;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OOR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALL_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALL_ID   = 1'd1;

  // Reset values of the configuration registers and the id counter.
  localparam logic [SIZE_W-1:0] ALL_SIZE_RST = 9'd1;
  localparam logic [ID_W-1:0]   ALL_ID_RST   = 16'd0;
  localparam logic [ID_W-1:0]   NEXT_ID_RST  = 16'd1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RD   = 2'd1,
    ST_CMP  = 2'd2
  } state_t;

endpackage

FILE: src/team_barrier_table_unit.sv
// Channel  | Direction | Handshake              | Beat contents
// ---------+-----------+------------------------+---------------------------------------
// in_      | input     | in_valid / in_ready    | mode, team_size, team_id, slot
// out_     | output    | out_valid / out_ready  | slot_out, team_id_out, status, released
// cfg_     | input     | cfg_we (no wait)       | cfg_index, cfg_wdata
//
// One item is handled at a time by a sequencer that walks the slot table with
// a single compare unit, visiting each slot with a memory read, then a compare.
// New team scans from slot 1 to the first free slot; find and delete scan from
// slot 0 up to the last slot; an arrival visits only the slot it names.
// Reset is synchronous, active low; the table needs no clearing pass.
// A result waits in the output register while the next beat is accepted; a full
// output register that is not being read holds the sequencer in its compare step.
module team_barrier_table_unit #(
  parameter int TEAM_SLOTS = tbt_pkg::TEAM_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tbt_pkg::MODE_W-1:0]      in_mode,
  input  logic [tbt_pkg::SIZE_W-1:0]      in_team_size,
  input  logic [tbt_pkg::ID_W-1:0]        in_team_id,
  input  logic [tbt_pkg::SLOT_W-1:0]      in_slot,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tbt_pkg::SLOTO_W-1:0]     out_slot_out,
  output logic [tbt_pkg::ID_W-1:0]        out_team_id_out,
  output logic [tbt_pkg::STATUS_W-1:0]    out_status,
  output logic                            out_released,
  // Configuration port
  input  logic                            cfg_we,
  input  logic [tbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbt_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  localparam int IW = (TEAM_SLOTS > 1) ? $clog2(TEAM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TEAM_SLOTS - 1);

  // Sequencer and latched item.
  tbt_pkg::state_t                state_r, state_nxt;
  tbt_pkg::mode_t                 mode_r;
  logic [tbt_pkg::SIZE_W-1:0]     tsize_r;
  logic [tbt_pkg::ID_W-1:0]       tid_r;
  logic                           oor_r;
  logic [IW-1:0]                  idx_r, idx_nxt;

  // Table state.
  logic [TEAM_SLOTS-1:0]          in_use_r;
  logic [tbt_pkg::SIZE_W-1:0]     cnt0_r;
  logic [tbt_pkg::ID_W-1:0]       next_id_r;
  logic [tbt_pkg::SIZE_W-1:0]     cfg_size_r;
  logic [tbt_pkg::ID_W-1:0]       cfg_id_r;

  logic [tbt_pkg::ID_W-1:0]       id_mem   [TEAM_SLOTS];
  logic [tbt_pkg::SIZE_W-1:0]     size_mem [TEAM_SLOTS];
  logic [tbt_pkg::SIZE_W-1:0]     cnt_mem  [TEAM_SLOTS];
  logic [tbt_pkg::ID_W-1:0]       rd_id_r;
  logic [tbt_pkg::SIZE_W-1:0]     rd_size_r;
  logic [tbt_pkg::SIZE_W-1:0]     rd_cnt_r;

  // Output register.
  logic                           out_valid_r;
  logic [tbt_pkg::SLOTO_W-1:0]    out_slot_r;
  logic [tbt_pkg::ID_W-1:0]       out_id_r;
  logic [tbt_pkg::STATUS_W-1:0]   out_status_r;
  logic                           out_rel_r;

  // Compare-step signals.
  logic                           in_acc;
  logic                           out_free;
  logic                           last;
  logic                           is_zero;
  logic                           cur_use;
  logic [tbt_pkg::ID_W-1:0]       cur_id;
  logic [tbt_pkg::SIZE_W-1:0]     cur_size;
  logic [tbt_pkg::SIZE_W-1:0]     cur_cnt;
  logic [tbt_pkg::SIZE_W:0]       cnt_inc;
  logic                           hit;
  logic                           done;
  logic                           finish;
  logic                           alloc_we;
  logic                           free_we;
  logic                           cnt_we;
  logic [tbt_pkg::SIZE_W-1:0]     cnt_wval;
  logic [tbt_pkg::SLOTO_W-1:0]    res_slot;
  logic [tbt_pkg::ID_W-1:0]       res_id;
  logic [tbt_pkg::STATUS_W-1:0]   res_status;
  logic                           res_rel;

  assign in_ready = (state_r == tbt_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Current slot as seen by the compare unit; slot 0 takes its id and size from configuration.
  assign last     = (idx_r == LAST_IDX);
  assign is_zero  = (idx_r == '0);
  assign cur_use  = in_use_r[idx_r];
  assign cur_id   = is_zero ? cfg_id_r   : rd_id_r;
  assign cur_size = is_zero ? cfg_size_r : rd_size_r;
  assign cur_cnt  = is_zero ? cnt0_r     : rd_cnt_r;
  assign cnt_inc  = {1'b0, cur_cnt} + (tbt_pkg::SIZE_W+1)'(1);

  // Compare unit: decides hit, completion and the result of the current step.
  always_comb begin
    hit        = 1'b0;
    done       = 1'b0;
    alloc_we   = 1'b0;
    free_we    = 1'b0;
    cnt_we     = 1'b0;
    cnt_wval   = '0;
    res_slot   = '0;
    res_id     = '0;
    res_status = tbt_pkg::STATUS_MISS;
    res_rel    = 1'b0;
    case (mode_r)
      tbt_pkg::MODE_NEW: begin
        hit  = !cur_use;
        done = hit || last;
        if (hit) begin
          alloc_we   = 1'b1;
          res_slot   = tbt_pkg::SLOTO_W'(idx_r);
          res_id     = next_id_r;
          res_status = tbt_pkg::STATUS_OK;
        end
      end
      tbt_pkg::MODE_FIND: begin
        hit  = cur_use && (cur_id == tid_r);
        done = hit || last;
        if (hit) begin
          res_slot   = tbt_pkg::SLOTO_W'(idx_r);
          res_status = tbt_pkg::STATUS_OK;
        end
      end
      tbt_pkg::MODE_DEL: begin
        hit  = cur_use && (cur_id == tid_r);
        done = hit || last;
        // The all-processes team matches first and is never freed.
        if (hit && !is_zero) begin
          free_we    = 1'b1;
          res_slot   = tbt_pkg::SLOTO_W'(idx_r);
          res_status = tbt_pkg::STATUS_OK;
        end
      end
      tbt_pkg::MODE_ARRIVE: begin
        done = 1'b1;
        if (oor_r) begin
          res_status = tbt_pkg::STATUS_OOR;
        end else if (cur_use) begin
          cnt_we     = 1'b1;
          res_slot   = tbt_pkg::SLOTO_W'(idx_r);
          res_status = tbt_pkg::STATUS_OK;
          if (cnt_inc >= {1'b0, cur_size}) begin
            res_rel  = 1'b1;
            cnt_wval = '0;
          end else begin
            cnt_wval = cnt_inc[tbt_pkg::SIZE_W-1:0];
          end
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign finish = (state_r == tbt_pkg::ST_CMP) && done && out_free;

  // Next state and scan index.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      tbt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = tbt_pkg::ST_RD;
          case (tbt_pkg::mode_t'(in_mode))
            tbt_pkg::MODE_NEW:    idx_nxt = IW'(1);
            tbt_pkg::MODE_ARRIVE: idx_nxt = IW'(in_slot);
            default:              idx_nxt = '0;
          endcase
        end
      end
      tbt_pkg::ST_RD: begin
        state_nxt = tbt_pkg::ST_CMP;
      end
      tbt_pkg::ST_CMP: begin
        if (!done) begin
          state_nxt = tbt_pkg::ST_RD;
          idx_nxt   = idx_r + IW'(1);
        end else if (out_free) begin
          state_nxt = tbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tbt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbt_pkg::ST_IDLE;
      in_use_r    <= TEAM_SLOTS'(1);
      cnt0_r      <= '0;
      next_id_r   <= tbt_pkg::NEXT_ID_RST;
      cfg_size_r  <= tbt_pkg::ALL_SIZE_RST;
      cfg_id_r    <= tbt_pkg::ALL_ID_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tbt_pkg::CFG_ALL_SIZE: cfg_size_r <= cfg_wdata[tbt_pkg::SIZE_W-1:0];
          tbt_pkg::CFG_ALL_ID:   cfg_id_r   <= cfg_wdata[tbt_pkg::ID_W-1:0];
          default: ;
        endcase
      end
      if (finish && alloc_we) begin
        in_use_r[idx_r] <= 1'b1;
        next_id_r       <= next_id_r + tbt_pkg::ID_W'(1);
      end
      if (finish && free_we) begin
        in_use_r[idx_r] <= 1'b0;
      end
      if (finish && cnt_we && is_zero) begin
        cnt0_r <= cnt_wval;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latched item and result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= tbt_pkg::mode_t'(in_mode);
      tsize_r <= in_team_size;
      tid_r   <= in_team_id;
      oor_r   <= ({1'b0, in_slot} >= (tbt_pkg::SLOT_W+1)'(TEAM_SLOTS));
    end
    idx_r <= idx_nxt;
    if (finish) begin
      out_slot_r   <= res_slot;
      out_id_r     <= res_id;
      out_status_r <= res_status;
      out_rel_r    <= res_rel;
    end
  end

  // Slot table memories: one write and one registered read at the scan index.
  always_ff @(posedge clk) begin
    if (finish && alloc_we) begin
      id_mem[idx_r]   <= next_id_r;
      size_mem[idx_r] <= tsize_r;
      cnt_mem[idx_r]  <= '0;
    end else if (finish && cnt_we && !is_zero) begin
      cnt_mem[idx_r]  <= cnt_wval;
    end
    rd_id_r   <= id_mem[idx_r];
    rd_size_r <= size_mem[idx_r];
    rd_cnt_r  <= cnt_mem[idx_r];
  end

  assign out_valid       = out_valid_r;
  assign out_slot_out    = out_slot_r;
  assign out_team_id_out = out_id_r;
  assign out_status      = out_status_r;
  assign out_released    = out_rel_r;

  // The all-processes team stays in use.
  a_slot0_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    in_use_r[0])
    else $error("slot 0 lost its in-use bit");

  // A failed beat reports neither a slot nor an id, and never a release.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != tbt_pkg::STATUS_OK) |->
      (out_slot_r == '0) && (out_id_r == '0) && !out_rel_r)
    else $error("failed beat carries slot, id or release");

  // The id counter moves only when a new team is created.
  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(finish && alloc_we) |=> $stable(next_id_r))
    else $error("team id counter moved without an allocation");

  // An accepted beat always starts with a table read.
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == tbt_pkg::ST_RD))
    else $error("accepted beat did not start a table read");

endmodule

FILE: dv/team_barrier_table_unit_tb.sv
module team_barrier_table_unit_tb;

  localparam int SLOTS        = tbt_pkg::TEAM_SLOTS_DEF;
  // Longest scan visits every slot; allow some margin after the last beat.
  localparam int SETTLE       = 2 * SLOTS + 8;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 112;

  // One request beat and one result beat, at the port widths.
  typedef struct packed {
    tbt_pkg::mode_t                mode;
    logic [tbt_pkg::SIZE_W-1:0]    size;
    logic [tbt_pkg::ID_W-1:0]      id;
    logic [tbt_pkg::SLOT_W-1:0]    slot;
  } team_req_t;

  typedef struct packed {
    logic [tbt_pkg::SLOTO_W-1:0]   slot;
    logic [tbt_pkg::ID_W-1:0]      id;
    logic [tbt_pkg::STATUS_W-1:0]  status;
    logic                          released;
  } team_resp_t;

  // A directed row, with its result typed in where it is obvious.
  typedef struct packed {
    team_req_t  req;
    logic       typed;
    team_resp_t resp;
  } team_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [tbt_pkg::MODE_W-1:0]    in_mode;
  logic [tbt_pkg::SIZE_W-1:0]    in_team_size;
  logic [tbt_pkg::ID_W-1:0]      in_team_id;
  logic [tbt_pkg::SLOT_W-1:0]    in_slot;
  logic                          out_valid;
  logic                          out_ready;
  logic [tbt_pkg::SLOTO_W-1:0]   out_slot_out;
  logic [tbt_pkg::ID_W-1:0]      out_team_id_out;
  logic [tbt_pkg::STATUS_W-1:0]  out_status;
  logic                          out_released;
  logic                          cfg_we;
  logic [tbt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tbt_pkg::CFG_DAT_W-1:0] cfg_wdata;

  // Fixed expectation that travels with the beat on the input channel.
  logic       fixed_valid;
  team_resp_t fixed_resp;

  // Team table as the block should hold it.
  bit                         slot_used [SLOTS];
  logic [tbt_pkg::ID_W-1:0]   team_id_tab [SLOTS];
  logic [tbt_pkg::SIZE_W-1:0] team_size_tab [SLOTS];
  int                         arrivals [SLOTS];
  logic [tbt_pkg::ID_W-1:0]   id_ctr;
  logic [tbt_pkg::SIZE_W-1:0] all_size;
  logic [tbt_pkg::ID_W-1:0]   all_id;

  team_resp_t pending_results[$];
  team_row_t  dir_rows[$];
  int         errors;
  int         stall_cycles;
  bit         steady;
  int         rx_hold;

  team_barrier_table_unit #(
    .TEAM_SLOTS(SLOTS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_team_size    (in_team_size),
    .in_team_id      (in_team_id),
    .in_slot         (in_slot),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_slot_out    (out_slot_out),
    .out_team_id_out (out_team_id_out),
    .out_status      (out_status),
    .out_released    (out_released),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic logic [tbt_pkg::ID_W-1:0] team_id_of(int s);
    return (s == 0) ? all_id : team_id_tab[s];
  endfunction

  // Returns to the post-reset table.
  task automatic clear_table();
    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s]     = (s == 0);
      team_id_tab[s]   = '0;
      team_size_tab[s] = '0;
      arrivals[s]      = 0;
    end
    id_ctr   = tbt_pkg::NEXT_ID_RST;
    all_size = tbt_pkg::ALL_SIZE_RST;
    all_id   = tbt_pkg::ALL_ID_RST;
  endtask

  // Applies one operation to the table and returns the result it gives.
  function automatic team_resp_t apply_team_op(team_req_t r);
    team_resp_t res;
    int         s;
    int         hit;
    int         cnt;
    int         limit;
    res = '0;
    res.status = tbt_pkg::STATUS_MISS;
    case (r.mode)
      tbt_pkg::MODE_NEW: begin
        s = 1;
        while (s < SLOTS && slot_used[s]) s++;
        if (s < SLOTS) begin
          slot_used[s]     = 1'b1;
          team_size_tab[s] = r.size;
          arrivals[s]      = 0;
          team_id_tab[s]   = id_ctr;
          res.id           = id_ctr;
          id_ctr           = id_ctr + 1'b1;
          res.slot         = tbt_pkg::SLOTO_W'(s);
          res.status       = tbt_pkg::STATUS_OK;
        end
      end
      tbt_pkg::MODE_FIND, tbt_pkg::MODE_DEL: begin
        // Lowest in-use slot with a matching id, slot 0 included.
        hit = SLOTS;
        for (s = SLOTS - 1; s >= 0; s--) begin
          if (slot_used[s] && team_id_of(s) == r.id) hit = s;
        end
        if (r.mode == tbt_pkg::MODE_FIND && hit < SLOTS) begin
          res.slot   = tbt_pkg::SLOTO_W'(hit);
          res.status = tbt_pkg::STATUS_OK;
        end else if (r.mode == tbt_pkg::MODE_DEL && hit >= 1 && hit < SLOTS) begin
          slot_used[hit] = 1'b0;
          res.slot       = tbt_pkg::SLOTO_W'(hit);
          res.status     = tbt_pkg::STATUS_OK;
        end
      end
      default: begin
        if (r.slot >= SLOTS) begin
          res.status = tbt_pkg::STATUS_OOR;
        end else if (slot_used[r.slot]) begin
          cnt   = arrivals[r.slot] + 1;
          limit = (r.slot == 0) ? int'(all_size) : int'(team_size_tab[r.slot]);
          // A count at or past the size releases, even after the size shrank.
          if (cnt >= limit) begin
            arrivals[r.slot] = 0;
            res.released     = 1'b1;
          end else begin
            arrivals[r.slot] = cnt % 512;
          end
          res.slot   = tbt_pkg::SLOTO_W'(r.slot);
          res.status = tbt_pkg::STATUS_OK;
        end
      end
    endcase
    return res;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Random request, mostly aimed at teams that exist, with noise in unused fields.
  function automatic team_req_t gen_team_req();
    team_req_t r;
    int        live[$];
    int        pick;
    int        k;
    r.size = tbt_pkg::SIZE_W'($urandom_range(1, 256));
    r.id   = tbt_pkg::ID_W'($urandom);
    r.slot = tbt_pkg::SLOT_W'($urandom_range(0, 255));
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_used[s]) live.push_back(s);
    end
    pick = live[$urandom_range(0, live.size() - 1)];
    k = $urandom_range(0, 99);
    if (k < 25) r.mode = tbt_pkg::MODE_NEW;
    else if (k < 45) r.mode = tbt_pkg::MODE_FIND;
    else if (k < 62) r.mode = tbt_pkg::MODE_DEL;
    else r.mode = tbt_pkg::MODE_ARRIVE;
    case (r.mode)
      tbt_pkg::MODE_NEW: begin
        k = $urandom_range(0, 9);
        if (k < 7) r.size = tbt_pkg::SIZE_W'($urandom_range(1, 4));
        else if (k == 7) r.size = tbt_pkg::SIZE_W'(256);
      end
      tbt_pkg::MODE_FIND, tbt_pkg::MODE_DEL: begin
        k = $urandom_range(0, 9);
        if (k < 7) r.id = team_id_of(pick);
        else if (k < 9) r.id = id_ctr - tbt_pkg::ID_W'($urandom_range(0, 3));
      end
      default: begin
        k = $urandom_range(0, 19);
        if (k < 15) r.slot = tbt_pkg::SLOT_W'(pick);
        else if (k < 18) r.slot = tbt_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
      end
    endcase
    return r;
  endfunction

  function automatic team_row_t mk_row(tbt_pkg::mode_t m, int size, int id, int slot,
                                       bit typed, int rslot, int rid,
                                       logic [tbt_pkg::STATUS_W-1:0] st, bit rel);
    team_row_t row;
    row.req.mode      = m;
    row.req.size      = tbt_pkg::SIZE_W'(size);
    row.req.id        = tbt_pkg::ID_W'(id);
    row.req.slot      = tbt_pkg::SLOT_W'(slot);
    row.typed         = typed;
    row.resp.slot     = tbt_pkg::SLOTO_W'(rslot);
    row.resp.id       = tbt_pkg::ID_W'(rid);
    row.resp.status   = st;
    row.resp.released = rel;
    return row;
  endfunction

  // Presents one beat after a random gap; returns at the falling edge after acceptance.
  task automatic send_req(input team_req_t r, input logic typed, input team_resp_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= r.mode;
    in_team_size <= r.size;
    in_team_id   <= r.id;
    in_slot      <= r.slot;
    fixed_valid  <= typed;
    fixed_resp   <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [tbt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tbt_pkg::CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == tbt_pkg::CFG_ALL_SIZE) all_size = val[tbt_pkg::SIZE_W-1:0];
    else all_id = val;
  endtask

  // Result side: random stalls, with calm stretches while steady is set.
  initial begin
    out_ready = 1'b0;
    rx_hold   = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) rx_hold = pick_gap();
      end
    end
  end

  // Checks each result beat against the oldest expectation, then records new ones.
  always @(posedge clk) begin : beat_monitor
    team_resp_t got;
    team_resp_t want;
    team_resp_t calc;
    team_req_t  req;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_slot_out, out_team_id_out, out_status, out_released};
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", got.status, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.slot != want.slot) report_mismatch("slot_out", got.slot, want.slot);
          if (got.id != want.id) report_mismatch("team_id_out", got.id, want.id);
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.released != want.released) begin
            report_mismatch("released", got.released, want.released);
          end
        end
      end
      if (in_valid && in_ready) begin
        req  = {tbt_pkg::mode_t'(in_mode), in_team_size, in_team_id, in_slot};
        calc = apply_team_op(req);
        pending_results.push_back(fixed_valid ? fixed_resp : calc);
      end
      // Watchdog on beats in either direction.
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Stimulus: reset, directed rows, then random phases under several settings.
  initial begin
    logic [tbt_pkg::CFG_DAT_W-1:0] size_val;
    logic [tbt_pkg::CFG_DAT_W-1:0] id_val;
    int                            hit;
    in_valid     = 1'b0;
    in_mode      = tbt_pkg::MODE_NEW;
    in_team_size = '0;
    in_team_id   = '0;
    in_slot      = '0;
    fixed_valid  = 1'b0;
    fixed_resp   = '0;
    cfg_we       = 1'b0;
    cfg_index    = tbt_pkg::CFG_ALL_SIZE;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    steady       = 1'b0;
    errors       = 0;
    stall_cycles = 0;
    clear_table();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows against the reset settings (slot 0 size 1, id 0).
    dir_rows.push_back(mk_row(tbt_pkg::MODE_ARRIVE, 0, 0, 0, 1, 0, 0,
                              tbt_pkg::STATUS_OK, 1));
    dir_rows.push_back(mk_row(tbt_pkg::MODE_FIND, 0, 0, 0, 1, 0, 0,
                              tbt_pkg::STATUS_OK, 0));
    // Deleting the all-processes team is refused.
    dir_rows.push_back(mk_row(tbt_pkg::MODE_DEL, 0, 0, 0, 1, 0, 0,
                              tbt_pkg::STATUS_MISS, 0));
    dir_rows.push_back(mk_row(tbt_pkg::MODE_NEW, 256, 0, 0, 1, 1, 1,
                              tbt_pkg::STATUS_OK, 0));
    dir_rows.push_back(mk_row(tbt_pkg::MODE_DEL, 0, 16'hFFFF, 0, 1, 0, 0,
                              tbt_pkg::STATUS_MISS, 0));
    dir_rows.push_back(mk_row(tbt_pkg::MODE_ARRIVE, 0, 0, 255, 1, 0, 0,
                              tbt_pkg::STATUS_OOR, 0));
    dir_rows.push_back(mk_row(tbt_pkg::MODE_ARRIVE, 0, 0, SLOTS, 1, 0, 0,
                              tbt_pkg::STATUS_OOR, 0));
    // Arrival at a slot that holds no team.
    dir_rows.push_back(mk_row(tbt_pkg::MODE_ARRIVE, 0, 0, SLOTS - 1, 1, 0, 0,
                              tbt_pkg::STATUS_MISS, 0));
    dir_rows.push_back(mk_row(tbt_pkg::MODE_ARRIVE, 0, 0, 1, 1, 1, 0,
                              tbt_pkg::STATUS_OK, 0));
    dir_rows.push_back(mk_row(tbt_pkg::MODE_FIND, 0, 1, 0, 0, 0, 0,
                              tbt_pkg::STATUS_OK, 0));
    // Fill the rest of the table; slot k gets id k.
    for (int k = 2; k < SLOTS; k++) begin
      dir_rows.push_back(mk_row(tbt_pkg::MODE_NEW,
                                (k % 3 == 0) ? 256 : (k % 3 == 1) ? 1 : k,
                                0, 0, 1, k, k, tbt_pkg::STATUS_OK, 0));
    end
    dir_rows.push_back(mk_row(tbt_pkg::MODE_NEW, 9, 0, 0, 1, 0, 0,
                              tbt_pkg::STATUS_MISS, 0));
    dir_rows.push_back(mk_row(tbt_pkg::MODE_ARRIVE, 0, 0, 2, 0, 0, 0,
                              tbt_pkg::STATUS_OK, 0));
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].resp);
    end

    // Random phases; each starts idle and rewrites both registers.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin size_val = 16'd256; id_val = 16'hFFFF; end
        1: begin
          // Shrink the size, which may drop it below the slot 0 count, and alias the lowest live team id.
          size_val = 16'd3;
          hit = 0;
          for (int s = SLOTS - 1; s >= 1; s--) if (slot_used[s]) hit = s;
          id_val = (hit != 0) ? team_id_tab[hit] : 16'd5;
        end
        2: begin size_val = 16'd1; id_val = 16'd0; end
        3: begin size_val = 16'($urandom_range(1, 256)); id_val = 16'($urandom); end
        4: begin size_val = 16'd2; id_val = id_ctr; end
        default: begin size_val = 16'($urandom_range(1, 8)); id_val = 16'h8000; end
      endcase
      write_reg(tbt_pkg::CFG_ALL_SIZE, size_val);
      write_reg(tbt_pkg::CFG_ALL_ID, id_val);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 59) == 0) drain_results();
        send_req(gen_team_req(), 1'b0, '0);
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/tbt_pkg.sv
src/team_barrier_table_unit.sv
dv/team_barrier_table_unit_tb.sv
